FILE: src/sdd_pkg.sv
// Shared types, constants and helpers for the steepest-descent direction block.
// No dependencies; imported by every module under src.
`timescale 1ns / 1ps

package sdd_pkg;

    // Fixed field widths
    localparam int SDD_SAMPLE_BITS   = 24;
    localparam int SDD_FRACTION_BITS = 8;
    localparam int SDD_PREC_BITS     = 16;
    localparam int SDD_ADDR_BITS     = 3;
    localparam int SDD_DATA_BITS     = 32;
    localparam int SDD_DIRS          = 8;
    localparam int SDD_DIR_BITS      = 3;

    localparam logic [SDD_PREC_BITS-1:0] SDD_PREC_RESET = 16'd10000;

    // Register index (paddr[2])
    localparam logic REG_PRECISION = 1'b0;

    // Direction codes
    localparam logic [3:0] DIR_EAST      = 4'd0;
    localparam logic [3:0] DIR_SOUTHEAST = 4'd1;
    localparam logic [3:0] DIR_SOUTH     = 4'd2;
    localparam logic [3:0] DIR_SOUTHWEST = 4'd3;
    localparam logic [3:0] DIR_WEST      = 4'd4;
    localparam logic [3:0] DIR_NORTHWEST = 4'd5;
    localparam logic [3:0] DIR_NORTH     = 4'd6;
    localparam logic [3:0] DIR_NORTHEAST = 4'd7;
    localparam logic [3:0] DIR_CENTER    = 4'd8;

    // Edge flag bits
    localparam int EDGE_FIRST_ROW = 0;
    localparam int EDGE_LAST_ROW  = 1;
    localparam int EDGE_FIRST_COL = 2;
    localparam int EDGE_LAST_COL  = 3;

    // Neighbors dropped per border, bit k = direction k
    localparam logic [SDD_DIRS-1:0] SKIP_FIRST_ROW = 8'hE0;
    localparam logic [SDD_DIRS-1:0] SKIP_LAST_ROW  = 8'h0E;
    localparam logic [SDD_DIRS-1:0] SKIP_FIRST_COL = 8'h38;
    localparam logic [SDD_DIRS-1:0] SKIP_LAST_COL  = 8'h83;

    typedef logic signed [SDD_SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t    center_value;
        sample_t    east_value;
        sample_t    southeast_value;
        sample_t    south_value;
        sample_t    southwest_value;
        sample_t    west_value;
        sample_t    northwest_value;
        sample_t    north_value;
        sample_t    northeast_value;
        logic [3:0] edge_flags;
    } win_t;

    typedef struct packed {
        logic [3:0] direction;
        logic [7:0] direction_mask;
    } res_t;

    // Per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_ctl_t;

    function automatic logic [SDD_DIRS-1:0] skip_of(input logic [3:0] flags);
        logic [SDD_DIRS-1:0] m;
        m = '0;
        if (flags[EDGE_FIRST_ROW]) m = m | SKIP_FIRST_ROW;
        if (flags[EDGE_LAST_ROW])  m = m | SKIP_LAST_ROW;
        if (flags[EDGE_FIRST_COL]) m = m | SKIP_FIRST_COL;
        if (flags[EDGE_LAST_COL])  m = m | SKIP_LAST_COL;
        return m;
    endfunction

endpackage

FILE: src/sdd_lane.sv
// One sample lane: scale by precision, then round to an integer key.
// Depends on sdd_pkg.
`timescale 1ns / 1ps

module sdd_lane #(
    parameter int FRACTION_BITS = 8,
    parameter int PROD_W        = 41,
    parameter int KEY_W         = 33
) (
    input  logic                              clk,
    input  sdd_pkg::pipe_ctl_t                ctl,
    input  sdd_pkg::sample_t                  sample,
    input  logic [sdd_pkg::SDD_PREC_BITS-1:0] precision,
    input  logic                              keep,
    output logic signed [KEY_W-1:0]           key,
    output logic                              key_keep
);
    import sdd_pkg::*;

    localparam logic [PROD_W-1:0] HALF =
        (FRACTION_BITS == 0) ? '0 : PROD_W'(1) << (FRACTION_BITS - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     keep1_reg;
    logic signed [PROD_W-1:0] rounded;
    logic signed [KEY_W-1:0]  key_reg;
    logic signed [KEY_W-1:0]  key_next;
    logic                     keep2_reg;

    // product of signed sample and unsigned precision; magnitude stays below 2^39
    assign prod_next = sample * $signed({1'b0, precision});
    assign rounded   = prod_reg + $signed(HALF);
    assign key_next  = KEY_W'(rounded >>> FRACTION_BITS);

    always_ff @(posedge clk)
    begin
        if (ctl.s1)
        begin
            prod_reg  <= prod_next;
            keep1_reg <= keep;
        end
        if (ctl.s2)
        begin
            key_reg   <= key_next;
            keep2_reg <= keep1_reg;
        end
    end

    assign key      = key_reg;
    assign key_keep = keep2_reg;

endmodule

FILE: src/sdd_merge.sv
// Merging tree over the eight neighbor keys, final compare against the center.
// Depends on sdd_pkg.
`timescale 1ns / 1ps

module sdd_merge #(
    parameter int KEY_W = 33
) (
    input  logic                          clk,
    input  sdd_pkg::pipe_ctl_t            ctl,
    input  logic signed [KEY_W-1:0]       center_key,
    input  logic signed [KEY_W-1:0]       nb_key [sdd_pkg::SDD_DIRS],
    input  logic [sdd_pkg::SDD_DIRS-1:0]  nb_keep,
    output sdd_pkg::res_t                 res
);
    import sdd_pkg::*;

    logic signed [KEY_W-1:0]  k3_reg [4];
    logic                     v3_reg [4];
    logic [SDD_DIR_BITS-1:0]  d3_reg [4];
    logic signed [KEY_W-1:0]  c3_reg;
    logic signed [KEY_W-1:0]  k4_reg [2];
    logic                     v4_reg [2];
    logic [SDD_DIR_BITS-1:0]  d4_reg [2];
    logic signed [KEY_W-1:0]  c4_reg;
    logic signed [KEY_W-1:0]  k3_next [4];
    logic                     v3_next [4];
    logic [SDD_DIR_BITS-1:0]  d3_next [4];
    logic signed [KEY_W-1:0]  k4_next [2];
    logic                     v4_next [2];
    logic [SDD_DIR_BITS-1:0]  d4_next [2];
    logic                     take_a;
    logic                     win_nb;
    logic [SDD_DIR_BITS-1:0]  win_dir;
    res_t                     res_reg;
    res_t                     res_next;

    // lower index wins ties; a dropped neighbor never wins
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (nb_keep[2*i] && (!nb_keep[2*i+1] || nb_key[2*i] <= nb_key[2*i+1]))
            begin
                k3_next[i] = nb_key[2*i];
                d3_next[i] = SDD_DIR_BITS'(2*i);
            end
            else
            begin
                k3_next[i] = nb_key[2*i+1];
                d3_next[i] = SDD_DIR_BITS'(2*i+1);
            end
            v3_next[i] = nb_keep[2*i] | nb_keep[2*i+1];
        end
        for (int i = 0; i < 2; i++)
        begin
            if (v3_reg[2*i] && (!v3_reg[2*i+1] || k3_reg[2*i] <= k3_reg[2*i+1]))
            begin
                k4_next[i] = k3_reg[2*i];
                d4_next[i] = d3_reg[2*i];
            end
            else
            begin
                k4_next[i] = k3_reg[2*i+1];
                d4_next[i] = d3_reg[2*i+1];
            end
            v4_next[i] = v3_reg[2*i] | v3_reg[2*i+1];
        end
    end

    // last level, then center check: the center loses ties
    always_comb
    begin
        take_a  = v4_reg[0] && (!v4_reg[1] || k4_reg[0] <= k4_reg[1]);
        win_dir = take_a ? d4_reg[0] : d4_reg[1];
        if (take_a)
            win_nb = k4_reg[0] <= c4_reg;
        else
            win_nb = v4_reg[1] && (k4_reg[1] <= c4_reg);
        if (win_nb)
        begin
            res_next.direction      = {1'b0, win_dir};
            res_next.direction_mask = 8'(1) << win_dir;
        end
        else
        begin
            res_next.direction      = DIR_CENTER;
            res_next.direction_mask = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s3)
        begin
            k3_reg <= k3_next;
            v3_reg <= v3_next;
            d3_reg <= d3_next;
            c3_reg <= center_key;
        end
        if (ctl.s4)
        begin
            k4_reg <= k4_next;
            v4_reg <= v4_next;
            d4_reg <= d4_next;
            c4_reg <= c3_reg;
        end
        if (ctl.s5)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

FILE: src/steepest_descent_direction.sv
// Steepest-descent direction: nine lanes scale in parallel, a 3-level tree merges.
// Throughput one window per clock unless the result channel stalls the pipeline.
// Stages: multiply, round, tree level 1, tree level 2, tree level 3 + center check.
// Reset clears all stage valid flags and loads precision with 10000.
// Depends on sdd_pkg, sdd_lane, sdd_merge.
`timescale 1ns / 1ps

module steepest_descent_direction #(
    parameter int FRACTION_BITS = sdd_pkg::SDD_FRACTION_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // window channel
    input  logic                              win_valid,
    output logic                              win_stall,
    input  sdd_pkg::win_t                     win,
    // result channel
    output logic                              res_valid,
    input  logic                              res_stall,
    output sdd_pkg::res_t                     res,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sdd_pkg::SDD_ADDR_BITS-1:0] paddr,
    input  logic [sdd_pkg::SDD_DATA_BITS-1:0] pwdata,
    output logic [sdd_pkg::SDD_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import sdd_pkg::*;

    // product of sample and zero-extended precision, then key after the shift
    localparam int PROD_W = SDD_SAMPLE_BITS + SDD_PREC_BITS + 1;
    localparam int KEY_W  = PROD_W - FRACTION_BITS;

    logic [SDD_PREC_BITS-1:0] precision_reg;

    // stage valid flags, stage 5 is the output register
    logic v1_reg, v2_reg, v3_reg, v4_reg, res_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    pipe_ctl_t ctl;

    sample_t                 samples [SDD_DIRS+1];
    logic [SDD_DIRS-1:0]     keep_in;
    logic signed [KEY_W-1:0] keys [SDD_DIRS+1];
    logic                    keeps [SDD_DIRS+1];
    logic signed [KEY_W-1:0] nb_key [SDD_DIRS];
    logic [SDD_DIRS-1:0]     nb_keep;

    // ------------------------------------------------------------------
    // Register port: zero-wait, one register at index 0
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            precision_reg <= SDD_PREC_RESET;
        else if (psel && penable && pwrite && paddr[2] == REG_PRECISION)
            precision_reg <= pwdata[SDD_PREC_BITS-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_PRECISION)
            prdata = SDD_DATA_BITS'(precision_reg);
    end

    // ------------------------------------------------------------------
    // Pipeline flow: a stage loads when it is empty or its successor moves.
    // The ready chain lets a bubble close up, so a new window is taken
    // while a finished result still waits on a stalled output.
    // ------------------------------------------------------------------
    assign rdy5 = !res_valid_reg || !res_stall;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign ctl.s1 = win_valid && rdy1;
    assign ctl.s2 = v1_reg && rdy2;
    assign ctl.s3 = v2_reg && rdy3;
    assign ctl.s4 = v3_reg && rdy4;
    assign ctl.s5 = v4_reg && rdy5;

    assign win_stall = !rdy1;
    assign res_valid = res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg        <= win_valid;
            if (rdy2) v2_reg        <= v1_reg;
            if (rdy3) v3_reg        <= v2_reg;
            if (rdy4) v4_reg        <= v3_reg;
            if (rdy5) res_valid_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Lanes: index 0 is the center, 1 + k is direction k
    // ------------------------------------------------------------------
    assign samples[0] = win.center_value;
    assign samples[1] = win.east_value;
    assign samples[2] = win.southeast_value;
    assign samples[3] = win.south_value;
    assign samples[4] = win.southwest_value;
    assign samples[5] = win.west_value;
    assign samples[6] = win.northwest_value;
    assign samples[7] = win.north_value;
    assign samples[8] = win.northeast_value;

    // neighbors outside the image are dropped before the tree
    assign keep_in = ~skip_of(win.edge_flags);

    for (genvar g = 0; g <= SDD_DIRS; g++)
    begin : g_lane
        sdd_lane #(
            .FRACTION_BITS (FRACTION_BITS),
            .PROD_W        (PROD_W),
            .KEY_W         (KEY_W)
        ) u_lane (
            .clk       (clk),
            .ctl       (ctl),
            .sample    (samples[g]),
            .precision (precision_reg),
            .keep      ((g == 0) ? 1'b1 : keep_in[(g == 0) ? 0 : g - 1]),
            .key       (keys[g]),
            .key_keep  (keeps[g])
        );
    end

    for (genvar g = 0; g < SDD_DIRS; g++)
    begin : g_nb
        assign nb_key[g]  = keys[g+1];
        assign nb_keep[g] = keeps[g+1];
    end

    // ------------------------------------------------------------------
    // Merge: min over kept neighbors, lowest index on ties, then against
    // the center key; result lands in the output register
    // ------------------------------------------------------------------
    sdd_merge #(
        .KEY_W (KEY_W)
    ) u_merge (
        .clk        (clk),
        .ctl        (ctl),
        .center_key (keys[0]),
        .nb_key     (nb_key),
        .nb_keep    (nb_keep),
        .res        (res)
    );

endmodule

FILE: tb/sv/steepest_descent_direction_test.sv
// Self-checking testbench for steepest_descent_direction: directed table, then random windows.
// Predicts untyped results in-bench, compares field by field; depends on sdd_pkg and the block RTL.
`timescale 1ns / 1ps

module steepest_descent_direction_test;

    import sdd_pkg::*;

    // Sample extremes of the signed Q15.8 field
    localparam sample_t S_MAX = 24'sh7FFFFF;
    localparam sample_t S_MIN = 24'sh800000;

    // Border flags as single-bit masks
    localparam logic [3:0] F_FIRST_ROW = 4'(1 << EDGE_FIRST_ROW);
    localparam logic [3:0] F_LAST_ROW  = 4'(1 << EDGE_LAST_ROW);
    localparam logic [3:0] F_FIRST_COL = 4'(1 << EDGE_FIRST_COL);
    localparam logic [3:0] F_LAST_COL  = 4'(1 << EDGE_LAST_COL);
    localparam logic [3:0] F_ALL       = F_FIRST_ROW | F_LAST_ROW | F_FIRST_COL | F_LAST_COL;

    localparam logic [SDD_ADDR_BITS-1:0] PRECISION_ADDR = {REG_PRECISION, 2'b00};

    localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transfer on either channel
    localparam int SETTLE_CYCLES   = 10;    // idle wait after the last owed result has come back
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int HOLD_CYCLES     = 64;    // long receiver hold-off to fill the pipe

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     win_valid;
    logic                     win_stall;
    win_t                     win;
    logic                     res_valid;
    logic                     res_stall;
    res_t                     res;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [SDD_ADDR_BITS-1:0] paddr;
    logic [SDD_DATA_BITS-1:0] pwdata;
    logic [SDD_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Side information travelling with the window being offered: a typed-in expectation
    // from the directed table replaces the predictor for that one transfer.
    bit                       win_typed;
    res_t                     win_typed_res;

    // Bench copy of the precision register
    logic [SDD_PREC_BITS-1:0] precision_model;

    // Results still owed by the block, oldest first
    res_t                     expected_dirs[$];

    int                       send_idle_pct;
    int                       recv_stall_pct;
    int                       hold_request;
    int                       quiet_cycles;
    int                       error_count;
    int                       windows_sent;
    int                       results_checked;
    int                       writes_done;
    int                       backpressure_cycles;

    typedef struct {
        win_t w;
        bit   typed;
        res_t want;
    } stim_row_t;

    stim_row_t directed_rows[$];

    steepest_descent_direction u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (win_valid),
        .win_stall (win_stall),
        .win       (win),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // floor((v * p + half) / 2^F), kept as a signed 64-bit key; order is all that matters
    function automatic longint scaled_key(input sample_t v, input logic [SDD_PREC_BITS-1:0] p);
        longint prod;
        prod = longint'(v) * longint'({48'd0, p});
        return (prod + (longint'(1) <<< (SDD_FRACTION_BITS - 1))) >>> SDD_FRACTION_BITS;
    endfunction

    // Lowest key wins; earlier direction wins among neighbors, center loses every tie.
    function automatic res_t steepest_dir(input win_t w, input logic [SDD_PREC_BITS-1:0] p);
        sample_t        nb [SDD_DIRS];
        logic [7:0]     skipped;
        longint         best;
        longint         key;
        logic [3:0]     best_dir;
        res_t           r;
        nb = '{w.east_value, w.southeast_value, w.south_value, w.southwest_value,
               w.west_value, w.northwest_value, w.north_value, w.northeast_value};
        skipped = ({8{w.edge_flags[EDGE_FIRST_ROW]}} & SKIP_FIRST_ROW)
                | ({8{w.edge_flags[EDGE_LAST_ROW]}}  & SKIP_LAST_ROW)
                | ({8{w.edge_flags[EDGE_FIRST_COL]}} & SKIP_FIRST_COL)
                | ({8{w.edge_flags[EDGE_LAST_COL]}}  & SKIP_LAST_COL);
        best     = scaled_key(w.center_value, p);
        best_dir = DIR_CENTER;
        for (int k = 0; k < SDD_DIRS; k++)
        begin
            if (!skipped[k])
            begin
                key = scaled_key(nb[k], p);
                // while the center still leads a tie is enough, after that a neighbor must beat
                if ((best_dir == DIR_CENTER) ? (key <= best) : (key < best))
                begin
                    best     = key;
                    best_dir = 4'(k);
                end
            end
        end
        r.direction      = best_dir;
        r.direction_mask = (best_dir == DIR_CENTER) ? 8'h00 : (8'h01 << best_dir);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic win_t make_win(input sample_t c, input sample_t e, input sample_t se,
                                      input sample_t s, input sample_t sw, input sample_t w,
                                      input sample_t nw, input sample_t n, input sample_t ne,
                                      input logic [3:0] f);
        win_t x;
        x.center_value    = c;
        x.east_value      = e;
        x.southeast_value = se;
        x.south_value     = s;
        x.southwest_value = sw;
        x.west_value      = w;
        x.northwest_value = nw;
        x.north_value     = n;
        x.northeast_value = ne;
        x.edge_flags      = f;
        return x;
    endfunction

    // style 0: anything; 1: close to base; 2: corner values; 3: plateau with rare dips
    function automatic sample_t rand_sample(input int style, input sample_t base);
        case (style)
            0: return sample_t'($urandom);
            1: return base + sample_t'($urandom_range(600)) - sample_t'(300);
            2:
            begin
                case ($urandom_range(5))
                    0: return S_MAX;
                    1: return S_MIN;
                    2: return sample_t'(0);
                    3: return sample_t'(-1);
                    4: return sample_t'(1);
                    default: return sample_t'($urandom);
                endcase
            end
            default: return ($urandom_range(7) == 0) ? base - sample_t'($urandom_range(1, 4))
                                                     : base;
        endcase
    endfunction

    function automatic win_t rand_window();
        int      style;
        sample_t base;
        logic [3:0] f;
        style = $urandom_range(3);
        base  = sample_t'($urandom);
        // mostly interior pixels so every direction gets a fair chance to win
        f = ($urandom_range(2) == 0) ? 4'($urandom_range(15)) : 4'h0;
        return make_win(rand_sample(style, base), rand_sample(style, base),
                        rand_sample(style, base), rand_sample(style, base),
                        rand_sample(style, base), rand_sample(style, base),
                        rand_sample(style, base), rand_sample(style, base),
                        rand_sample(style, base), f);
    endfunction

    function automatic void push_row(input win_t w, input bit typed, input res_t want);
        stim_row_t r;
        r.w     = w;
        r.typed = typed;
        r.want  = want;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // Register word for each phase; last phase carries junk above the 16 used bits
    function automatic logic [31:0] phase_word(input int ph);
        case (ph)
            0: return 32'd65535;
            1: return 32'd1;
            2: return 32'd0;
            3: return 32'd256;
            4: return 32'd10000;
            5: return 32'($urandom_range(1, 65535));
            6: return 32'd2;
            default: return {16'hA5A5, 16'd12345};
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_window(input win_t w, input bit typed, input res_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            win_valid <= 1'b0;
            @(negedge clk);
        end
        win_valid     <= 1'b1;
        win           <= w;
        win_typed     <= typed;
        win_typed_res <= want;
        do
            @(posedge clk);
        while (win_stall);
        @(negedge clk);
    endtask

    // Idle the window channel and wait for every owed result; called at a falling edge.
    task automatic drain_results();
        win_valid <= 1'b0;
        while (expected_dirs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Write precision, then read it back (back-to-back APB transfers).
    task automatic set_precision(input logic [31:0] data);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PRECISION_ADDR;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        precision_model = data[SDD_PREC_BITS-1:0];
        writes_done++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[SDD_PREC_BITS-1:0] !== precision_model)
        begin
            $error("precision readback: expected %0d, actual %0d",
                   precision_model, prdata[SDD_PREC_BITS-1:0]);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus an on-request long hold-off counted here
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                n            = hold_request;
                hold_request = 0;
                res_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor / scoreboard, sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Pop before push: a result this cycle can only belong to an earlier window.
            if (res_valid && !res_stall)
            begin
                if (expected_dirs.size() == 0)
                begin
                    $error("result transfer with nothing expected: direction %0d mask %02h",
                           res.direction, res.direction_mask);
                    error_count++;
                end
                else
                begin
                    res_t want;
                    want = expected_dirs.pop_front();
                    if (res.direction !== want.direction)
                    begin
                        $error("direction: expected %0d, actual %0d",
                               want.direction, res.direction);
                        error_count++;
                    end
                    if (res.direction_mask !== want.direction_mask)
                    begin
                        $error("direction_mask: expected %02h, actual %02h",
                               want.direction_mask, res.direction_mask);
                        error_count++;
                    end
                    results_checked++;
                end
            end
            if (win_valid && !win_stall)
            begin
                expected_dirs.insert(expected_dirs.size(),
                                     win_typed ? win_typed_res
                                               : steepest_dir(win, precision_model));
                windows_sent++;
            end
            if (win_valid && win_stall)
                backpressure_cycles++;
        end
    end

    // Watchdog: too long without any transfer means the block is stuck
    always @(posedge clk)
    begin
        if (!rst_n || (win_valid && !win_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        win_t w;

        rst_n               = 1'b0;
        win_valid           = 1'b0;
        win                 = '0;
        win_typed           = 1'b0;
        win_typed_res       = '0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        precision_model     = SDD_PREC_RESET;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        hold_request        = 0;
        error_count         = 0;
        windows_sent        = 0;
        results_checked     = 0;
        writes_done         = 0;
        backpressure_cycles = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed table, run at the reset precision with no idling ---
        // flat windows: every key equal, east wins
        push_row(make_win(0, 0, 0, 0, 0, 0, 0, 0, 0, 4'h0), 1'b1, '{DIR_EAST, 8'h01});
        push_row(make_win(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 4'h0),
                 1'b1, '{DIR_EAST, 8'h01});
        push_row(make_win(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 4'h0),
                 1'b1, '{DIR_EAST, 8'h01});
        // center strictly lowest
        push_row(make_win(S_MIN, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 4'h0),
                 1'b1, '{DIR_CENTER, 8'h00});
        // every neighbor masked off by the four borders
        push_row(make_win(S_MAX, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, F_ALL),
                 1'b1, '{DIR_CENTER, 8'h00});
        // one low neighbor per direction
        for (int k = 0; k < SDD_DIRS; k++)
        begin
            sample_t v [SDD_DIRS];
            foreach (v[i])
                v[i] = (i == k) ? S_MIN : S_MAX;
            push_row(make_win(S_MAX, v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], 4'h0),
                     1'b1, '{4'(k), 8'h01 << k});
        end
        // first column still keeps the south neighbor
        push_row(make_win(S_MAX, S_MAX, S_MAX, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                          F_FIRST_COL), 1'b1, '{DIR_SOUTH, 8'h04});
        // center ties the lowest neighbor and loses
        push_row(make_win(S_MIN, S_MAX, S_MAX, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 4'h0),
                 1'b1, '{DIR_SOUTH, 8'h04});
        // two neighbors tie: lower index wins
        push_row(make_win(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 4'h0),
                 1'b1, '{DIR_EAST, 8'h01});
        // border skips with the low value hidden, and flag combinations
        push_row(make_win(100, 50, 60, 70, 80, -900, 90, 95, 99, F_FIRST_COL), 1'b0, '0);
        push_row(make_win(100, 50, 60, 70, 80, 85, 90, -900, 99, F_FIRST_ROW), 1'b0, '0);
        push_row(make_win(5, -3, -9, 4, 7, 2, -1, 6, 8, F_LAST_ROW | F_LAST_COL), 1'b0, '0);
        push_row(make_win(5, -3, -9, 4, 7, 2, -1, 6, 8, F_FIRST_ROW | F_LAST_ROW), 1'b0, '0);
        push_row(make_win(5, -3, -9, 4, 7, 2, -1, 6, 8, F_FIRST_COL | F_LAST_COL), 1'b0, '0);
        // rounding near zero: one LSB apart, negative side included
        push_row(make_win(0, 1, 1, 1, 1, 1, 1, 1, 1, 4'h0), 1'b0, '0);
        push_row(make_win(0, -1, 0, -2, 1, 0, -1, 2, 0, 4'h0), 1'b0, '0);

        foreach (directed_rows[i])
            send_window(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);

        // --- random phases: new precision each phase, rotating idle/stall mixes ---
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_precision(phase_word(ph));
            case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            // sender keeps pushing while the receiver holds off: the pipe fills up
            if (ph == 4)
                hold_request = HOLD_CYCLES;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // mid-phase pause until the block has handed back everything
                if (ph == 2 && i == ITEMS_PER_PHASE / 2)
                    drain_results();
                w = rand_window();
                send_window(w, 1'b0, '0);
            end
        end

        drain_results();

        $display("Sent %0d windows, checked %0d results over %0d precision writes.",
                 windows_sent, results_checked, writes_done);
        $display("Idle/stall mixes and a long receiver hold-off gave %0d input stall cycles.",
                 backpressure_cycles);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
src/sdd_pkg.sv
src/sdd_lane.sv
src/sdd_merge.sv
src/steepest_descent_direction.sv
tb/sv/steepest_descent_direction_test.sv
